/* rtl/sdg_pkg.sv */
// Shared types and constants for the step/direction generator.
`timescale 1ns / 1ps
package sdg_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ENGAGE    = 3'd1,
    CMD_DISENGAGE = 3'd2,
    CMD_MOVE      = 3'd3,
    CMD_RUN       = 3'd4,
    CMD_STOP      = 3'd5,
    CMD_ZERO      = 3'd6,
    CMD_ABORT     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    REG_STEP_PERIOD   = 2'd0,
    REG_STEPS_PER_REV = 2'd1,
    REG_PULSE_WIDTH   = 2'd2
  } reg_idx_t;

  localparam int CMD_W    = 3;
  localparam int DEG_W    = 24;
  localparam int PERIOD_W = 32;
  localparam int SPR_W    = 16;
  localparam int PW_W     = 16;
  localparam int POS_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Largest step count: (2^24-1) * 65535 / 92160 stays under 2^24.
  localparam int STEPS_W = 24;

  // 92160 = 2048 * 45: shift out 2048, then divide by 45 through a reciprocal.
  localparam int PROD_W      = DEG_W + SPR_W;
  localparam int DIV_SHIFT   = 11;
  localparam int X_W         = PROD_W - DIV_SHIFT;
  localparam int MAGIC_W     = 30;
  localparam int MAGIC_SHIFT = 35;
  localparam int PROD2_W     = X_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] DIV45_MAGIC = 30'd763549742;

  localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 32'd1250;
  localparam logic [SPR_W-1:0]    RST_SPR         = 16'd200;
  localparam logic [PW_W-1:0]     RST_PULSE_WIDTH = 16'd10;

  typedef struct packed {
    cmd_t             cmd;
    logic [DEG_W-1:0] degrees_q8;
    logic             forward;
  } in_word_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               forward;
    logic [STEPS_W-1:0] steps;
  } mv_word_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] step_period;
    logic [SPR_W-1:0]    steps_per_rev;
    logic [PW_W-1:0]     pulse_width;
  } cfg_regs_t;

  typedef struct packed {
    logic                    step;
    logic                    dir;
    logic                    enable_n;
    logic                    enabled;
    logic                    moving;
    logic signed [POS_W-1:0] position;
  } status_t;

endpackage

/* rtl/sdg_intf.sv */
// Channel interfaces for command words, status words and register writes.
`timescale 1ns / 1ps
interface sdg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [23:0] degrees_q8;
  logic        forward;
  modport source (output valid, cmd, degrees_q8, forward, input ready);
  modport sink (input valid, cmd, degrees_q8, forward, output ready);
endinterface

interface sdg_out_if;
  logic               valid;
  logic               ready;
  logic               step_out;
  logic               dir_out;
  logic               enable_n_out;
  logic               is_enabled;
  logic               is_moving;
  logic signed [31:0] step_position;
  modport source (output valid, step_out, dir_out, enable_n_out, is_enabled, is_moving,
                  step_position, input ready);
  modport sink (input valid, step_out, dir_out, enable_n_out, is_enabled, is_moving,
                step_position, output ready);
endinterface

interface sdg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sdg_div_pipe.sv */
// Three-stage front end: registers the command word and turns degrees into steps.
`timescale 1ns / 1ps
module sdg_div_pipe import sdg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  input  logic [SPR_W-1:0] steps_per_rev,
  output logic             mv_valid,
  input  logic             mv_ready,
  output mv_word_t         mv_word
);

  logic             v1_r, v2_r, v3_r;
  logic             en1, en2, en3;
  cmd_t             cmd1_r, cmd2_r, cmd3_r;
  logic             fwd1_r, fwd2_r, fwd3_r;
  logic [PROD_W-1:0]  prod1_r;
  logic [X_W-1:0]   x2_r;
  logic [STEPS_W-1:0] steps3_r;
  logic [PROD_W-1:0]  prod1;
  logic [PROD2_W-1:0] prod2;

  // Each stage advances when it is empty or its successor advances.
  assign en3      = !v3_r || mv_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign prod1 = {{SPR_W{1'b0}}, in_word.degrees_q8} * {{DEG_W{1'b0}}, steps_per_rev};
  assign prod2 = {{MAGIC_W{1'b0}}, x2_r} * {{X_W{1'b0}}, DIV45_MAGIC};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage one holds the word and its degree product; stage two drops the factor 2048.
  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r  <= in_word.cmd;
      fwd1_r  <= in_word.forward;
      prod1_r <= prod1;
    end
    if (en2) begin
      cmd2_r <= cmd1_r;
      fwd2_r <= fwd1_r;
      x2_r   <= prod1_r[PROD_W-1:DIV_SHIFT];
    end
    if (en3) begin
      cmd3_r   <= cmd2_r;
      fwd3_r   <= fwd2_r;
      steps3_r <= prod2[MAGIC_SHIFT +: STEPS_W];
    end
  end

  assign mv_valid      = v3_r;
  assign mv_word.cmd   = cmd3_r;
  assign mv_word.forward = fwd3_r;
  assign mv_word.steps = steps3_r;

endmodule

/* rtl/sdg_motion.sv */
// Motion state: pin levels, step timing, position count and the result register.
`timescale 1ns / 1ps
module sdg_motion import sdg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mv_valid,
  output logic      mv_ready,
  input  mv_word_t  mv_word,
  input  cfg_regs_t cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output status_t   status
);

  logic                    out_valid_r, out_valid_nxt;
  logic                    enabled_r, enabled_nxt;
  logic                    enable_n_r, enable_n_nxt;
  logic                    dir_r, dir_nxt;
  logic                    step_r, step_nxt;
  logic                    moving_r, moving_nxt;
  logic                    stop_pend_r, stop_pend_nxt;
  logic                    run_forever_r, run_forever_nxt;
  logic [STEPS_W-1:0]      steps_rem_r, steps_rem_nxt;
  logic [PERIOD_W-1:0]     timer_r, timer_nxt;
  logic                    high_phase_r, high_phase_nxt;
  logic signed [POS_W-1:0] position_r, position_nxt;

  logic                    take;
  logic                    seq_done;
  logic [PERIOD_W-1:0]     low_len;
  logic signed [POS_W-1:0] pos_fin;
  logic [STEPS_W-1:0]      rem_fin;
  logic                    end_fin;

  assign mv_ready = !out_valid_r || out_ready;
  assign take     = mv_valid && mv_ready;

  // A sequence ends before a new step when stopped or when no steps remain.
  assign seq_done = stop_pend_r || (!run_forever_r && steps_rem_r == '0);

  assign low_len = (cfg.step_period > {{(PERIOD_W-PW_W){1'b0}}, cfg.pulse_width}) ?
                   cfg.step_period - {{(PERIOD_W-PW_W){1'b0}}, cfg.pulse_width} : '0;

  // Values left by the end of a step.
  assign pos_fin = dir_r ? position_r + POS_W'(1) : position_r - POS_W'(1);
  assign rem_fin = (!run_forever_r && steps_rem_r != '0) ? steps_rem_r - STEPS_W'(1)
                                                           : steps_rem_r;
  assign end_fin = stop_pend_r || (!run_forever_r && rem_fin == '0);

  always_comb begin
    enabled_nxt     = enabled_r;
    enable_n_nxt    = enable_n_r;
    dir_nxt         = dir_r;
    step_nxt        = step_r;
    moving_nxt      = moving_r;
    stop_pend_nxt   = stop_pend_r;
    run_forever_nxt = run_forever_r;
    steps_rem_nxt   = steps_rem_r;
    timer_nxt       = timer_r;
    high_phase_nxt  = high_phase_r;
    position_nxt    = position_r;
    unique case (mv_word.cmd)
      CMD_TICK: begin
        if (moving_r) begin
          if (high_phase_r) begin
            if (timer_r != '0) begin
              timer_nxt = timer_r - PERIOD_W'(1);
            end else begin
              step_nxt       = 1'b0;
              high_phase_nxt = 1'b0;
              if (low_len <= PERIOD_W'(1)) begin
                timer_nxt     = '0;
                position_nxt  = pos_fin;
                steps_rem_nxt = rem_fin;
                if (end_fin) begin
                  moving_nxt      = 1'b0;
                  run_forever_nxt = 1'b0;
                  stop_pend_nxt   = 1'b0;
                end
              end else begin
                timer_nxt = low_len - PERIOD_W'(1);
              end
            end
          end else if (timer_r != '0) begin
            timer_nxt = timer_r - PERIOD_W'(1);
            if (timer_r == PERIOD_W'(1)) begin
              position_nxt  = pos_fin;
              steps_rem_nxt = rem_fin;
              if (end_fin) begin
                moving_nxt      = 1'b0;
                run_forever_nxt = 1'b0;
                stop_pend_nxt   = 1'b0;
              end
            end
          end else if (seq_done) begin
            moving_nxt      = 1'b0;
            run_forever_nxt = 1'b0;
            stop_pend_nxt   = 1'b0;
          end else begin
            step_nxt       = 1'b1;
            high_phase_nxt = 1'b1;
            timer_nxt      = (cfg.pulse_width != '0) ?
                             {{(PERIOD_W-PW_W){1'b0}}, cfg.pulse_width - PW_W'(1)} : '0;
          end
        end
      end
      CMD_ENGAGE: begin
        enable_n_nxt = 1'b0;
        enabled_nxt  = 1'b1;
      end
      CMD_DISENGAGE: begin
        enable_n_nxt = 1'b1;
        enabled_nxt  = 1'b0;
      end
      CMD_MOVE: begin
        if (enabled_r && !moving_r) begin
          stop_pend_nxt   = 1'b0;
          dir_nxt         = mv_word.forward;
          run_forever_nxt = 1'b0;
          steps_rem_nxt   = mv_word.steps;
          timer_nxt       = '0;
          high_phase_nxt  = 1'b0;
          moving_nxt      = (mv_word.steps != '0);
        end
      end
      CMD_RUN: begin
        if (enabled_r && !moving_r) begin
          stop_pend_nxt   = 1'b0;
          dir_nxt         = mv_word.forward;
          run_forever_nxt = 1'b1;
          steps_rem_nxt   = '0;
          timer_nxt       = '0;
          high_phase_nxt  = 1'b0;
          moving_nxt      = 1'b1;
        end
      end
      CMD_STOP: begin
        if (moving_r) stop_pend_nxt = 1'b1;
      end
      CMD_ZERO: begin
        position_nxt = '0;
      end
      CMD_ABORT: begin
        // Drop every pin and all motion; the logical enable flag stays.
        enable_n_nxt    = 1'b1;
        step_nxt        = 1'b0;
        dir_nxt         = 1'b0;
        moving_nxt      = 1'b0;
        stop_pend_nxt   = 1'b0;
        run_forever_nxt = 1'b0;
        steps_rem_nxt   = '0;
        timer_nxt       = '0;
        high_phase_nxt  = 1'b0;
      end
      default: begin
        moving_nxt = moving_r;
      end
    endcase
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      enabled_r     <= 1'b0;
      enable_n_r    <= 1'b1;
      dir_r         <= 1'b0;
      step_r        <= 1'b0;
      moving_r      <= 1'b0;
      stop_pend_r   <= 1'b0;
      run_forever_r <= 1'b0;
      steps_rem_r   <= '0;
      timer_r       <= '0;
      high_phase_r  <= 1'b0;
      position_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        enabled_r     <= enabled_nxt;
        enable_n_r    <= enable_n_nxt;
        dir_r         <= dir_nxt;
        step_r        <= step_nxt;
        moving_r      <= moving_nxt;
        stop_pend_r   <= stop_pend_nxt;
        run_forever_r <= run_forever_nxt;
        steps_rem_r   <= steps_rem_nxt;
        timer_r       <= timer_nxt;
        high_phase_r  <= high_phase_nxt;
        position_r    <= position_nxt;
      end
    end
  end

  // The state after the last word is the result word; it holds while stalled.
  assign out_valid       = out_valid_r;
  assign status.step     = step_r;
  assign status.dir      = dir_r;
  assign status.enable_n = enable_n_r;
  assign status.enabled  = enabled_r;
  assign status.moving   = moving_r;
  assign status.position = position_r;

endmodule

/* rtl/stepper_step_dir_generator_core.sv */
// Top level of the step/direction pulse generator.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : command words (cmd, degrees_q8, forward). A tick word advances
//            step timing by one microsecond; the other codes are commands.
//   out_ch : one status word per command word, in order: pin levels, flags
//            and the signed position after that word.
//   cfg_ch : register writes (index, data), always ready. Write only while
//            the block is idle.
// Timing: a taken word passes the product, shifted product and quotient stages
//   and then the motion state register, which holds its status word.
//   One word per cycle is taken while out_ch is ready; the degree-to-step product feeds a
//   reciprocal multiply by 1/45, each in its own stage.
// Reset: step and dir low, enable_n high (driver disabled), position zero,
//   registers at their defaults. No clearing pass is needed.
// Stall: when out_ch is not ready the result register holds and the stages
//   in front fill up; in_ch stays ready until every stage holds a word.
module stepper_step_dir_generator_core import sdg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sdg_in_if.sink     in_ch,
  sdg_out_if.source  out_ch,
  sdg_cfg_if.sink    cfg_ch
);

  cfg_regs_t cfg_r;
  in_word_t  in_word;
  mv_word_t  mv_word;
  logic      mv_valid;
  logic      mv_ready;
  status_t   status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period   <= RST_STEP_PERIOD;
      cfg_r.steps_per_rev <= RST_SPR;
      cfg_r.pulse_width   <= RST_PULSE_WIDTH;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_STEP_PERIOD:   cfg_r.step_period   <= cfg_ch.data;
        REG_STEPS_PER_REV: cfg_r.steps_per_rev <= cfg_ch.data[SPR_W-1:0];
        REG_PULSE_WIDTH:   cfg_r.pulse_width   <= cfg_ch.data[PW_W-1:0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  assign in_word.cmd        = cmd_t'(in_ch.cmd);
  assign in_word.degrees_q8 = in_ch.degrees_q8;
  assign in_word.forward    = in_ch.forward;

  sdg_div_pipe u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_word       (in_word),
    .steps_per_rev (cfg_r.steps_per_rev),
    .mv_valid      (mv_valid),
    .mv_ready      (mv_ready),
    .mv_word       (mv_word)
  );

  sdg_motion u_motion (
    .clk       (clk),
    .rst_n     (rst_n),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_word   (mv_word),
    .cfg       (cfg_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status)
  );

  assign out_ch.step_out      = status.step;
  assign out_ch.dir_out       = status.dir;
  assign out_ch.enable_n_out  = status.enable_n;
  assign out_ch.is_enabled    = status.enabled;
  assign out_ch.is_moving     = status.moving;
  assign out_ch.step_position = status.position;

endmodule

/* test/stepper_step_dir_generator_core_tb.sv */
// Self-checking testbench for the step/direction pulse generator core.
`timescale 1ns / 1ps
module stepper_step_dir_generator_core_tb;
  import sdg_pkg::*;

  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned CALM_FROM    = 500;
  localparam int unsigned CALM_TO      = 700;
  localparam int unsigned HOLD_AT      = 540;
  localparam int unsigned HOLD_LEN     = 80;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned DEG_PER_REV  = 92160;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    bit        enabled;
    bit        enable_n;
    bit        dir;
    bit        step;
    bit        moving;
    bit        stop_req;
    bit        free_run;
    bit        high_phase;
    bit [31:0] steps_left;
    bit [31:0] timer;
    bit [31:0] position;
  } motor_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sdg_in_if  cmd_bus ();
  sdg_out_if status_bus ();
  sdg_cfg_if reg_bus ();

  stepper_step_dir_generator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (status_bus),
    .cfg_ch (reg_bus)
  );

  always #4 clk = ~clk;

  // Motor model state and its copy of the registers
  motor_state_t    motor;
  bit [31:0]       period_cfg = RST_STEP_PERIOD;
  bit [15:0]       spr_cfg    = RST_SPR;
  bit [15:0]       pw_cfg     = RST_PULSE_WIDTH;

  in_word_t        word_queue[$];
  status_t         status_due[$];
  in_word_t        word_on_bus;
  status_t         want;

  int unsigned     words_planned = 0;
  int unsigned     words_taken = 0;
  int unsigned     results_seen = 0;
  int unsigned     settings_used = 0;
  int unsigned     steps_done = 0;
  int unsigned     motions_begun = 0;
  int unsigned     errors = 0;
  int unsigned     hold_left = 0;
  int unsigned     stall_cycles = 0;
  bit              hold_done = 1'b0;
  bit              sender_rests;

  function automatic void halt_motion();
    motor.moving   = 1'b0;
    motor.free_run = 1'b0;
    motor.stop_req = 1'b0;
  endfunction

  function automatic void close_step();
    if (motor.dir) motor.position = motor.position + 1;
    else motor.position = motor.position - 1;
    steps_done++;
    if (!motor.free_run && motor.steps_left != 0) motor.steps_left = motor.steps_left - 1;
    if (motor.stop_req || (!motor.free_run && motor.steps_left == 0)) halt_motion();
  endfunction

  function automatic void motor_tick();
    bit [31:0] low_len;
    if (!motor.moving) return;
    if (motor.high_phase) begin
      if (motor.timer != 0) begin
        motor.timer = motor.timer - 1;
      end else begin
        low_len = (period_cfg > pw_cfg) ? period_cfg - pw_cfg : 32'd0;
        motor.step = 1'b0;
        motor.high_phase = 1'b0;
        // the pin must be seen low for at least one tick
        if (low_len <= 1) begin
          motor.timer = 0;
          close_step();
        end else begin
          motor.timer = low_len - 1;
        end
      end
    end else if (motor.timer != 0) begin
      motor.timer = motor.timer - 1;
      if (motor.timer == 0) close_step();
    end else if (motor.stop_req || (!motor.free_run && motor.steps_left == 0)) begin
      halt_motion();
    end else begin
      motor.step = 1'b1;
      motor.high_phase = 1'b1;
      motor.timer = (pw_cfg != 0) ? pw_cfg - 1 : 32'd0;
    end
  endfunction

  function automatic void start_motion(bit fwd, bit endless, bit [31:0] count);
    motor.stop_req   = 1'b0;
    motor.dir        = fwd;
    motor.free_run   = endless;
    motor.steps_left = endless ? 32'd0 : count;
    motor.timer      = 0;
    motor.high_phase = 1'b0;
    motor.moving     = endless || (count != 0);
    if (motor.moving) motions_begun++;
  endfunction

  function automatic status_t motor_apply(in_word_t w);
    bit [47:0] prod;
    status_t   s;
    case (w.cmd)
      CMD_TICK: motor_tick();
      CMD_ENGAGE: begin
        motor.enable_n = 1'b0;
        motor.enabled  = 1'b1;
      end
      CMD_DISENGAGE: begin
        motor.enable_n = 1'b1;
        motor.enabled  = 1'b0;
      end
      CMD_MOVE: begin
        if (motor.enabled && !motor.moving) begin
          prod = 48'(w.degrees_q8) * 48'(spr_cfg);
          start_motion(w.forward, 1'b0, 32'(prod / DEG_PER_REV));
        end
      end
      CMD_RUN: begin
        if (motor.enabled && !motor.moving) start_motion(w.forward, 1'b1, 32'd0);
      end
      CMD_STOP: begin
        if (motor.moving) motor.stop_req = 1'b1;
      end
      CMD_ZERO: motor.position = 0;
      default: begin
        // abort: drop every pin, keep the logical enabled flag
        motor.enable_n   = 1'b1;
        motor.step       = 1'b0;
        motor.dir        = 1'b0;
        motor.moving     = 1'b0;
        motor.stop_req   = 1'b0;
        motor.free_run   = 1'b0;
        motor.steps_left = 0;
        motor.timer      = 0;
        motor.high_phase = 1'b0;
      end
    endcase
    s.step     = motor.step;
    s.dir      = motor.dir;
    s.enable_n = motor.enable_n;
    s.enabled  = motor.enabled;
    s.moving   = motor.moving;
    s.position = motor.position;
    return s;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch on status word %0d: expected %h, got %h",
               $time, what, results_seen, exp_v, got_v);
    end
  endtask

  // Driver: present one word at a time, predict its status on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        status_due.push_back(motor_apply(word_on_bus));
        words_taken++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        sender_rests = (words_taken < CALM_FROM || words_taken >= CALM_TO) &&
                       ($urandom_range(99) < IDLE_PCT);
        if (word_queue.size() != 0 && !sender_rests) begin
          word_on_bus = word_queue.pop_front();
          cmd_bus.valid      <= 1'b1;
          cmd_bus.cmd        <= word_on_bus.cmd;
          cmd_bus.degrees_q8 <= word_on_bus.degrees_q8;
          cmd_bus.forward    <= word_on_bus.forward;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each status word and throttle ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      status_bus.ready <= 1'b0;
    end else begin
      if (status_bus.valid && status_bus.ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: status word %0d arrived with nothing expected", $time, results_seen);
        end else begin
          want = status_due.pop_front();
          compare_field("step_out", 32'(want.step), 32'(status_bus.step_out));
          compare_field("dir_out", 32'(want.dir), 32'(status_bus.dir_out));
          compare_field("enable_n_out", 32'(want.enable_n), 32'(status_bus.enable_n_out));
          compare_field("is_enabled", 32'(want.enabled), 32'(status_bus.is_enabled));
          compare_field("is_moving", 32'(want.moving), 32'(status_bus.is_moving));
          compare_field("step_position", want.position, status_bus.step_position);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      status_bus.ready <= (hold_left == 0) &&
                          ((results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                           ($urandom_range(99) >= IDLE_PCT));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) ||
        (status_bus.valid && status_bus.ready) || (reg_bus.valid && reg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("stepper_step_dir_generator_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [DEG_W-1:0] rand_deg();
    return DEG_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic push_word(input cmd_t c, input logic [DEG_W-1:0] deg, input logic fwd);
    word_queue.push_back('{cmd: c, degrees_q8: deg, forward: fwd});
    words_planned++;
  endtask

  task automatic push_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) push_word(CMD_ZERO, rand_deg(), rand_bit());
      else push_word(CMD_TICK, rand_deg(), rand_bit());
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (word_queue.size() != 0 || status_due.size() != 0 || cmd_bus.valid);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= val;
    do @(posedge clk);
    while (!reg_bus.ready);
    case (idx)
      REG_STEP_PERIOD:   period_cfg = val;
      REG_STEPS_PER_REV: spr_cfg    = val[SPR_W-1:0];
      REG_PULSE_WIDTH:   pw_cfg     = val[PW_W-1:0];
      default: ;
    endcase
    reg_bus.valid <= 1'b0;
  endtask

  // One well-formed motion sequence with random content, or a little noise
  task automatic queue_burst(input int unsigned step_ticks);
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    logic        fwd;
    pick = $urandom_range(99);
    fwd  = rand_bit();
    if (pick < 45) begin
      if ($urandom_range(99) < 40) push_word(CMD_ENGAGE, rand_deg(), rand_bit());
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(5);
        push_word(CMD_MOVE,
                  DEG_W'((k * DEG_PER_REV + $urandom_range(DEG_PER_REV - 1)) / spr_cfg), fwd);
        n = k * step_ticks + 3;
        if ($urandom_range(99) < 15) begin
          push_ticks($urandom_range(n));
          push_word(CMD_STOP, rand_deg(), rand_bit());
          n = step_ticks + 3;
        end
        push_ticks(n);
      end else begin
        push_word(CMD_MOVE, rand_deg(), fwd);
        push_ticks($urandom_range(5, 40));
        if ($urandom_range(99) < 70) begin
          push_word(CMD_ABORT, rand_deg(), rand_bit());
        end else begin
          push_word(CMD_STOP, rand_deg(), rand_bit());
          push_ticks(step_ticks + 3);
        end
      end
    end else if (pick < 70) begin
      if ($urandom_range(99) < 40) push_word(CMD_ENGAGE, rand_deg(), rand_bit());
      push_word(CMD_RUN, rand_deg(), fwd);
      push_ticks($urandom_range(3, 3 * step_ticks));
      if ($urandom_range(1)) push_word(CMD_STOP, rand_deg(), rand_bit());
      else push_word(CMD_ABORT, rand_deg(), rand_bit());
      push_ticks(step_ticks + 3);
    end else if (pick < 80) begin
      push_word(CMD_DISENGAGE, rand_deg(), rand_bit());
      push_ticks($urandom_range(1, step_ticks));
      if ($urandom_range(1)) push_word(CMD_MOVE, rand_deg(), fwd);
      push_word(CMD_ENGAGE, rand_deg(), rand_bit());
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 6)) push_word(cmd_t'($urandom_range(7)), rand_deg(), rand_bit());
    end else begin
      push_ticks($urandom_range(1, 10));
    end
  endtask

  task automatic run_phase(input logic [31:0] period, input logic [31:0] spr_word,
                           input logic [31:0] pw_word, input int unsigned quota);
    int unsigned goal;
    int unsigned step_ticks;
    wait_for_drain();
    write_reg(REG_STEP_PERIOD, period);
    write_reg(REG_STEPS_PER_REV, spr_word);
    write_reg(REG_PULSE_WIDTH, pw_word);
    settings_used++;
    // slow settings never finish a step here; those bursts end in abort or stay stuck
    if (period_cfg > 40 || pw_cfg > 40) step_ticks = 40;
    else step_ticks = ((period_cfg > pw_cfg) ? period_cfg : pw_cfg) + 2;
    goal = words_planned + quota;
    while (words_planned < goal) queue_burst(step_ticks);
    // leave no motion behind for the next setting
    push_word(CMD_ABORT, rand_deg(), rand_bit());
  endtask

  initial begin
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = '0;
    cmd_bus.degrees_q8 = '0;
    cmd_bus.forward    = 1'b0;
    status_bus.ready   = 1'b0;
    reg_bus.valid      = 1'b0;
    reg_bus.index      = '0;
    reg_bus.data       = '0;
    motor = '{enable_n: 1'b1, default: '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // unused register index must change nothing
    write_reg(REG_SPARE, $urandom);

    // Directed words at reset settings
    push_word(CMD_MOVE, 24'hFF_FFFF, 1'b1);
    push_word(CMD_RUN, 24'h00_0000, 1'b1);
    push_word(CMD_STOP, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'hFF_FFFF, 1'b1);
    push_word(CMD_ENGAGE, 24'h00_0000, 1'b0);
    push_word(CMD_MOVE, 24'h00_0000, 1'b1);
    push_word(CMD_MOVE, 24'd460, 1'b0);
    push_word(CMD_MOVE, 24'd461, 1'b0);
    push_word(CMD_MOVE, 24'hFF_FFFF, 1'b1);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_ZERO, 24'h00_0000, 1'b0);
    push_word(CMD_DISENGAGE, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_ABORT, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_ENGAGE, 24'h00_0000, 1'b0);
    push_word(CMD_RUN, 24'hFF_FFFF, 1'b1);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_STOP, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_TICK, 24'h00_0000, 1'b0);
    push_word(CMD_ABORT, 24'hFF_FFFF, 1'b1);

    run_phase(32'd0, 32'd1, 32'd1, 150);
    run_phase(32'd1, 32'd65535, 32'd1, 150);
    run_phase(32'd2, 32'd200, 32'd1, 150);
    run_phase(32'd4, 32'd400, 32'd2, 150);
    run_phase(32'hFFFF_FFFF, 32'd65535, 32'd65535, 80);
    run_phase(32'd6, $urandom_range(1, 65535), 32'd3, 150);
    // upper data bits of a 16-bit register are dropped
    run_phase(32'd3, 32'h5A5A_0001, 32'hA5A5_0005, 150);
    run_phase($urandom_range(2, 10), $urandom_range(1, 65535), $urandom_range(1, 8), 150);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d command words over %0d register settings: %0d motions, %0d steps.",
             words_taken, settings_used, motions_begun, steps_done);
    $display("Checked %0d status words, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("stepper_step_dir_generator_core_tb OK");
    end else begin
      $display("stepper_step_dir_generator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sdg_pkg.sv
rtl/sdg_intf.sv
rtl/sdg_div_pipe.sv
rtl/sdg_motion.sv
rtl/stepper_step_dir_generator_core.sv
test/stepper_step_dir_generator_core_tb.sv
